// ----- rtl/givr_pkg.sv -----
// Shared types, constants and rounding helpers for the gyro increment vector rotation unit.
package givr_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int RATE_W     = 16;
    localparam int PERIOD_W   = 16;
    localparam int PHASE_W    = 24;
    localparam int TRIG_W     = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;
    localparam logic [PHASE_W-1:0]  QUARTER_TURN = 24'h40_0000;

    // Register stages in each sub-pipeline.
    localparam int PHASE_LAT = 5;
    localparam int SINE_LAT  = 12;

    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vec_in_x;
        logic signed [DATA_WIDTH-1:0] vec_in_y;
        logic signed [DATA_WIDTH-1:0] vec_in_z;
        logic signed [RATE_W-1:0]     rate_x;
        logic signed [RATE_W-1:0]     rate_y;
        logic signed [RATE_W-1:0]     rate_z;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vec_out_x;
        logic signed [DATA_WIDTH-1:0] vec_out_y;
        logic signed [DATA_WIDTH-1:0] vec_out_z;
    } out_t;

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (sh - 1);
        if (v >= 0) begin
            mag = 64'(v);
            return $signed((mag + half) >> sh);
        end
        mag = 64'(-v);
        return -$signed((mag + half) >> sh);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] saturate(input logic signed [63:0] v);
        if (v > SAT_MAX) begin
            return DATA_WIDTH'(SAT_MAX);
        end
        if (v < SAT_MIN) begin
            return DATA_WIDTH'(SAT_MIN);
        end
        return DATA_WIDTH'(v);
    endfunction

endpackage

// ----- rtl/gyro_increment_vector_rotation_unit.sv -----
// Top level: rotates a vector by the small rotation of one gyro sample period.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      givr_pkg::in_t  (vector and rates)
//   m_        out        m_valid / m_ready      givr_pkg::out_t (rotated vector)
//   cfg_      in         cfg_we                 sample period in microseconds
//
// One transaction is taken every cycle while the pipeline advances.
// The depth is set by the phase divider (5 stages), the sine series (12) and the
// matrix and dot products (6). The whole pipeline advances together and holds when
// the output register is full and not taken. Reset clears the valid bits and sets
// the period to 2000 us.
module gyro_increment_vector_rotation_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [givr_pkg::PERIOD_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  givr_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output givr_pkg::out_t                    m_data
);

    localparam int DW      = givr_pkg::DATA_WIDTH;
    localparam int VEC_DLY = givr_pkg::PHASE_LAT + givr_pkg::SINE_LAT + 3;
    localparam int LAT     = givr_pkg::PHASE_LAT + givr_pkg::SINE_LAT + 6;
    localparam int PROD_W  = DW + 32;
    localparam int SUM_W   = DW + 34;

    logic [givr_pkg::PERIOD_W-1:0] period_reg;
    logic [LAT-1:0]                vld_reg;
    logic                          en;

    givr_pkg::in_t vec_dly_reg [VEC_DLY];

    logic [givr_pkg::PHASE_W-1:0] ph_x, ph_y, ph_z;
    logic signed [givr_pkg::TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

    // First matrix stage: two-factor products.
    logic signed [31:0] czcy_reg, cysz_reg, szcx_reg, czsx_reg;
    logic signed [31:0] szsx_reg, czcx_reg, sxcy_reg, cycx_reg;
    logic signed [15:0] sy1_reg;
    // Second stage: three-factor products.
    logic signed [31:0] czcy2_reg, cysz2_reg, szcx2_reg, czsx2_reg;
    logic signed [31:0] szsx2_reg, czcx2_reg, sxcy2_reg, cycx2_reg;
    logic signed [15:0] sy2_reg;
    logic signed [47:0] t_czsx_reg, t_szsx_reg, t_czcx_reg, t_szcx_reg;

    logic signed [31:0]       mat_reg [9];
    logic signed [31:0]       mat_next [9];
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [SUM_W-1:0]  sum_next [3];
    logic signed [DW-1:0]     vec_arr [3];
    logic signed [DW-1:0]     res_next [3];
    givr_pkg::out_t           out_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= givr_pkg::PERIOD_RESET;
            vld_reg    <= '0;
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
        end
    end

    givr_phase u_phase_x (.aclk(aclk), .en(en), .rate(s_data.rate_x),
                          .period(period_reg), .phase(ph_x));
    givr_phase u_phase_y (.aclk(aclk), .en(en), .rate(s_data.rate_y),
                          .period(period_reg), .phase(ph_y));
    givr_phase u_phase_z (.aclk(aclk), .en(en), .rate(s_data.rate_z),
                          .period(period_reg), .phase(ph_z));

    // Cosine is the sine a quarter turn on.
    givr_sine u_sin_x (.aclk(aclk), .en(en), .phase(ph_x), .sine(sx));
    givr_sine u_cos_x (.aclk(aclk), .en(en), .phase(ph_x + givr_pkg::QUARTER_TURN), .sine(cx));
    givr_sine u_sin_y (.aclk(aclk), .en(en), .phase(ph_y), .sine(sy));
    givr_sine u_cos_y (.aclk(aclk), .en(en), .phase(ph_y + givr_pkg::QUARTER_TURN), .sine(cy));
    givr_sine u_sin_z (.aclk(aclk), .en(en), .phase(ph_z), .sine(sz));
    givr_sine u_cos_z (.aclk(aclk), .en(en), .phase(ph_z + givr_pkg::QUARTER_TURN), .sine(cz));

    always_comb begin
        mat_next[0] = czcy2_reg;
        mat_next[1] = -cysz2_reg;
        mat_next[2] = 32'(sy2_reg) <<< 14;
        mat_next[3] = szcx2_reg + 32'(givr_pkg::rnd_shift(64'(t_czsx_reg), 14));
        mat_next[4] = czcx2_reg - 32'(givr_pkg::rnd_shift(64'(t_szsx_reg), 14));
        mat_next[5] = -sxcy2_reg;
        mat_next[6] = szsx2_reg - 32'(givr_pkg::rnd_shift(64'(t_czcx_reg), 14));
        mat_next[7] = czsx2_reg + 32'(givr_pkg::rnd_shift(64'(t_szcx_reg), 14));
        mat_next[8] = cycx2_reg;

        vec_arr[0] = vec_dly_reg[VEC_DLY-1].vec_in_x;
        vec_arr[1] = vec_dly_reg[VEC_DLY-1].vec_in_y;
        vec_arr[2] = vec_dly_reg[VEC_DLY-1].vec_in_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r*3+c] = PROD_W'(vec_arr[r]) * PROD_W'(mat_reg[r*3+c]);
            end
        end

        for (int j = 0; j < 3; j++) begin
            sum_next[j] = SUM_W'(prod_reg[j]) + SUM_W'(prod_reg[3+j]) + SUM_W'(prod_reg[6+j]);
            res_next[j] = givr_pkg::saturate(givr_pkg::rnd_shift(64'(sum_reg[j]), 28));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_dly_reg[0] <= s_data;
            for (int k = 1; k < VEC_DLY; k++) begin
                vec_dly_reg[k] <= vec_dly_reg[k-1];
            end

            czcy_reg <= cz * cy;
            cysz_reg <= cy * sz;
            szcx_reg <= sz * cx;
            czsx_reg <= cz * sx;
            szsx_reg <= sz * sx;
            czcx_reg <= cz * cx;
            sxcy_reg <= sx * cy;
            cycx_reg <= cy * cx;
            sy1_reg  <= sy;

            czcy2_reg  <= czcy_reg;
            cysz2_reg  <= cysz_reg;
            szcx2_reg  <= szcx_reg;
            czsx2_reg  <= czsx_reg;
            szsx2_reg  <= szsx_reg;
            czcx2_reg  <= czcx_reg;
            sxcy2_reg  <= sxcy_reg;
            cycx2_reg  <= cycx_reg;
            sy2_reg    <= sy1_reg;
            t_czsx_reg <= 48'(czsx_reg) * 48'(sy1_reg);
            t_szsx_reg <= 48'(szsx_reg) * 48'(sy1_reg);
            t_czcx_reg <= 48'(czcx_reg) * 48'(sy1_reg);
            t_szcx_reg <= 48'(szcx_reg) * 48'(sy1_reg);

            for (int i = 0; i < 9; i++) begin
                mat_reg[i]  <= mat_next[i];
                prod_reg[i] <= prod_next[i];
            end
            for (int j = 0; j < 3; j++) begin
                sum_reg[j] <= sum_next[j];
            end

            out_reg.vec_out_x <= res_next[0];
            out_reg.vec_out_y <= res_next[1];
            out_reg.vec_out_z <= res_next[2];
        end
    end

endmodule

// ----- rtl/givr_phase.sv -----
// Pipeline that turns a gyro rate and the sample period into a phase in 2^-24 turn.
module givr_phase (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [givr_pkg::RATE_W-1:0]   rate,
    input  logic [givr_pkg::PERIOD_W-1:0]        period,
    output logic [givr_pkg::PHASE_W-1:0]         phase
);

    // 5.76e9 = 2^13 * 703125, so the rounded quotient is
    // floor((mag * 2^11 + 351562) / 703125), found by a reciprocal and one correction.
    localparam logic [63:0] PH_DIV64  = 64'd703125;
    localparam logic [19:0] PH_DIV    = 20'(PH_DIV64);
    localparam logic [42:0] PH_HALF   = 43'd351562;
    localparam logic [31:0] PH_RECIP  = 32'((64'd1 << 51) / PH_DIV64);
    localparam logic [63:0] PH_BIAS   = (64'd351562 << 40) / PH_DIV64;

    logic [16:0] absr_reg, absr_next;
    logic        neg1_reg;
    logic [31:0] mag_reg;
    logic        neg2_reg;
    logic [23:0] q0_reg;
    logic [42:0] num3_reg, num3_next;
    logic        neg3_reg;
    logic [43:0] qd_reg, qd_next;
    logic [42:0] num4_reg;
    logic [23:0] q04_reg;
    logic        neg4_reg;
    logic [23:0] phase_reg, phase_next;

    logic [16:0] rate_ext;
    logic [32:0] mag_full;
    logic [63:0] prod;
    logic [43:0] rem;
    logic [23:0] quo;

    always_comb begin
        rate_ext  = {rate[givr_pkg::RATE_W-1], rate};
        absr_next = rate_ext[16] ? (~rate_ext + 17'd1) : rate_ext;
        mag_full  = {16'd0, absr_reg} * {17'd0, period};
        prod      = {32'd0, mag_reg} * {32'd0, PH_RECIP} + PH_BIAS;
        num3_next = {mag_reg, 11'd0} + PH_HALF;
        qd_next   = {20'd0, q0_reg} * {24'd0, PH_DIV};
        rem       = {1'b0, num4_reg} - qd_reg;
        quo       = q04_reg + ((rem >= {24'd0, PH_DIV}) ? 24'd1 : 24'd0);
        phase_next = neg4_reg ? (24'd0 - quo) : quo;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            absr_reg  <= absr_next;
            neg1_reg  <= rate[givr_pkg::RATE_W-1];
            mag_reg   <= mag_full[31:0];
            neg2_reg  <= neg1_reg;
            q0_reg    <= prod[63:40];
            num3_reg  <= num3_next;
            neg3_reg  <= neg2_reg;
            qd_reg    <= qd_next;
            num4_reg  <= num3_reg;
            q04_reg   <= q0_reg;
            neg4_reg  <= neg3_reg;
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ----- rtl/givr_sine.sv -----
// Pipelined fixed-point sine of a 24-bit phase, Taylor series in Horner form, Q1.14 result.
module givr_sine (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [givr_pkg::PHASE_W-1:0]         phase,
    output logic signed [givr_pkg::TRIG_W-1:0]   sine
);

    localparam logic [39:0] TWO_PI_Q37 = 40'd863554413089;
    localparam logic [19:0] TP_HI      = TWO_PI_Q37[39:20];
    localparam logic [19:0] TP_LO      = TWO_PI_Q37[19:0];
    localparam logic [29:0] Q29_ONE    = 30'd536870912;
    // Rounded-up reciprocals; exact floor division for the operand widths used below.
    localparam logic [31:0] RECIP9     = 32'(((64'd1 << 32) + 64'd8) / 64'd9);
    localparam logic [31:0] RECIP21    = 32'(((64'd1 << 35) + 64'd20) / 64'd21);
    localparam logic [31:0] RECIP5     = 32'(((64'd1 << 32) + 64'd4) / 64'd5);
    localparam logic [31:0] RECIP3     = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
    localparam logic [15:0] TRIG_ONE   = 16'd16384;

    logic [22:0] t_reg, t_next;
    logic [10:0] neg_reg;
    logic [42:0] pa_reg, pb_reg;
    logic [29:0] x_reg [9];
    logic [30:0] x2_reg [6];
    logic [29:0] f1_reg, f2_reg, f3_reg, f4_reg;
    logic [29:0] f1_next, f2_next, f3_next, f4_next;
    logic [30:0] h1_reg, h2_reg, h3_reg;
    logic signed [15:0] sine_reg, sine_next;

    logic [63:0] xsum;
    logic [59:0] sq;
    logic [60:0] sqr;
    logic [59:0] d9;
    logic [60:0] hp1, hp2, hp3;
    logic [61:0] d21;
    logic [60:0] d5;
    logic [61:0] d3;
    logic [59:0] sp;
    logic [31:0] rr;
    logic [15:0] mag;

    always_comb begin
        // Fold the phase onto a quarter turn; the upper half turn flips the sign.
        t_next = phase[22] ? (23'h40_0000 - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
        xsum   = {1'b0, pa_reg, 20'd0} + {21'd0, pb_reg} + 64'h8000_0000;
        sq     = x_reg[0] * x_reg[0];
        sqr    = {1'b0, sq} + 61'h1000_0000;
        d9     = x2_reg[0][30:3] * RECIP9;
        f1_next = Q29_ONE - {2'd0, d9[59:32]};
        hp1    = x2_reg[1] * f1_reg;
        d21    = h1_reg[30:1] * RECIP21;
        f2_next = Q29_ONE - {3'd0, d21[61:35]};
        hp2    = x2_reg[3] * f2_reg;
        d5     = h2_reg[30:2] * RECIP5;
        f3_next = Q29_ONE - {1'b0, d5[60:32]};
        hp3    = x2_reg[5] * f3_reg;
        d3     = h3_reg[30:1] * RECIP3;
        f4_next = Q29_ONE - d3[61:32];
        sp     = x_reg[8] * f4_reg;
        rr     = {1'b0, sp[59:29]} + 32'd16384;
        mag    = (rr[31:15] > {1'b0, TRIG_ONE}) ? TRIG_ONE : rr[30:15];
        sine_next = neg_reg[10] ? $signed(16'd0 - mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg   <= t_next;
            neg_reg <= {neg_reg[9:0], phase[23]};
            pa_reg  <= t_reg * TP_HI;
            pb_reg  <= t_reg * TP_LO;
            x_reg[0] <= xsum[61:32];
            for (int k = 1; k < 9; k++) begin
                x_reg[k] <= x_reg[k-1];
            end
            x2_reg[0] <= sqr[59:29];
            for (int k = 1; k < 6; k++) begin
                x2_reg[k] <= x2_reg[k-1];
            end
            f1_reg   <= f1_next;
            h1_reg   <= hp1[59:29];
            f2_reg   <= f2_next;
            h2_reg   <= hp2[59:29];
            f3_reg   <= f3_next;
            h3_reg   <= hp3[59:29];
            f4_reg   <= f4_next;
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

// ----- verif/tb_gyro_increment_vector_rotation_unit.sv -----
// Self-checking testbench for the gyro increment vector rotation unit.
module tb_gyro_increment_vector_rotation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH  = 23;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [63:0] TWO_PI_Q37_C = 64'd863554413089;
    localparam logic [63:0] Q29_ONE_C    = 64'd536870912;
    localparam logic [63:0] RATE_DIV_C   = 64'd5760000000;
    localparam longint      Q14_ONE_C    = 16384;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [givr_pkg::PERIOD_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    givr_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    givr_pkg::out_t m_data;

    gyro_increment_vector_rotation_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    givr_pkg::in_t  pending_samples[$];
    givr_pkg::out_t rotated_vectors[$];
    logic [givr_pkg::PERIOD_W-1:0] period_us = givr_pkg::PERIOD_RESET;
    int   error_count = 0;
    int   cycle_count = 0;
    bit   calm = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;

    function automatic longint round_shift(longint v, int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v >= 0) begin
            return (v + half) >>> sh;
        end
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint quarter_sin(logic [23:0] t);
        logic [63:0] x, x2, f, s, r;
        x  = (64'(t) * TWO_PI_Q37_C + (64'd1 << 31)) >> 32;
        x2 = (x * x + (64'd1 << 28)) >> 29;
        f  = Q29_ONE_C - x2 / 72;
        f  = Q29_ONE_C - ((x2 * f) >> 29) / 42;
        f  = Q29_ONE_C - ((x2 * f) >> 29) / 20;
        f  = Q29_ONE_C - ((x2 * f) >> 29) / 6;
        s  = (x * f) >> 29;
        r  = (s + (64'd1 << 14)) >> 15;
        if (r > 64'(Q14_ONE_C)) begin
            r = 64'(Q14_ONE_C);
        end
        return longint'(r);
    endfunction

    function automatic longint sine_of_phase(logic [23:0] p);
        logic [1:0]  q;
        logic [21:0] r;
        longint v;
        q = p[23:22];
        r = p[21:0];
        if (q[0]) begin
            v = quarter_sin(24'h40_0000 - 24'(r));
        end else begin
            v = quarter_sin(24'(r));
        end
        return q[1] ? -v : v;
    endfunction

    function automatic logic [23:0] phase_of_rate(logic signed [15:0] rate);
        logic [63:0] mag, ph;
        logic [23:0] m;
        mag = 64'(rate < 0 ? -int'(rate) : int'(rate)) * 64'(period_us);
        ph  = (mag * (64'd1 << 24) + RATE_DIV_C / 2) / RATE_DIV_C;
        m   = ph[23:0];
        if (rate < 0) begin
            m = 24'd0 - m;
        end
        return m;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic givr_pkg::out_t rotate_vector(givr_pkg::in_t d);
        logic [23:0] px, py, pz;
        longint sx, cx, sy, cy, sz, cz, vx, vy, vz;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        givr_pkg::out_t o;
        px = phase_of_rate(d.rate_x);
        py = phase_of_rate(d.rate_y);
        pz = phase_of_rate(d.rate_z);
        sx = sine_of_phase(px); cx = sine_of_phase(px + 24'h40_0000);
        sy = sine_of_phase(py); cy = sine_of_phase(py + 24'h40_0000);
        sz = sine_of_phase(pz); cz = sine_of_phase(pz + 24'h40_0000);
        vx = d.vec_in_x; vy = d.vec_in_y; vz = d.vec_in_z;
        m00 = cz * cy;
        m01 = -(cy * sz);
        m02 = sy * Q14_ONE_C;
        m10 = sz * cx + round_shift(cz * sx * sy, 14);
        m11 = cz * cx - round_shift(sz * sx * sy, 14);
        m12 = -(sx * cy);
        m20 = sz * sx - round_shift(cz * cx * sy, 14);
        m21 = cz * sx + round_shift(sz * cx * sy, 14);
        m22 = cy * cx;
        o.vec_out_x = clamp16(round_shift(vx * m00 + vy * m10 + vz * m20, 28));
        o.vec_out_y = clamp16(round_shift(vx * m01 + vy * m11 + vz * m21, 28));
        o.vec_out_z = clamp16(round_shift(vx * m02 + vy * m12 + vz * m22, 28));
        return o;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic givr_pkg::in_t random_sample();
        givr_pkg::in_t d;
        d.vec_in_x = pick_value();
        d.vec_in_y = pick_value();
        d.vec_in_z = pick_value();
        d.rate_x = pick_value();
        d.rate_y = pick_value();
        d.rate_z = pick_value();
        return d;
    endfunction

    // Driver: the prediction is made when the transaction is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rotated_vectors.push_back(rotate_vector(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 17);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver back-pressure.
    always @(posedge aclk) begin
        givr_pkg::out_t exp_v;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (rotated_vectors.size() == 0) begin
                    $error("unexpected result %h", m_data);
                    error_count = error_count + 1;
                end else begin
                    exp_v = rotated_vectors.pop_front();
                    if (m_data.vec_out_x !== exp_v.vec_out_x) begin
                        $error("vec_out_x expected %0d actual %0d",
                               exp_v.vec_out_x, m_data.vec_out_x);
                        error_count = error_count + 1;
                    end
                    if (m_data.vec_out_y !== exp_v.vec_out_y) begin
                        $error("vec_out_y expected %0d actual %0d",
                               exp_v.vec_out_y, m_data.vec_out_y);
                        error_count = error_count + 1;
                    end
                    if (m_data.vec_out_z !== exp_v.vec_out_z) begin
                        $error("vec_out_z expected %0d actual %0d",
                               exp_v.vec_out_z, m_data.vec_out_z);
                        error_count = error_count + 1;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_valid || rotated_vectors.size() > 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic set_period(logic [givr_pkg::PERIOD_W-1:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        period_us = v;
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_samples.push_back(random_sample());
    endtask

    initial begin
        givr_pkg::in_t d;
        logic [15:0] edge_vals[4];
        edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes and two fixed samples at the reset period, then random samples at zero period.
        for (int i = 0; i < 4; i++) begin
            d = '{edge_vals[i], edge_vals[(i+1)%4], edge_vals[(i+2)%4],
                  edge_vals[i], edge_vals[(i+3)%4], edge_vals[(i+1)%4]};
            pending_samples.push_back(d);
        end
        d = '{16'sh4000, 16'sh4000, 16'shc000, 16'sd1440, 16'sd0, 16'shfa60};
        pending_samples.push_back(d);
        d = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0};
        pending_samples.push_back(d);
        wait_drained();
        set_period(16'd0);
        for (int i = 0; i < 6; i++) pending_samples.push_back(random_sample());
        wait_drained();
        // Maximum period gives large wrapped angles.
        set_period(16'hffff);
        for (int i = 0; i < 4; i++) begin
            d = '{edge_vals[i], edge_vals[3-i], 16'sh4000,
                  edge_vals[(i+1)%4], edge_vals[i], edge_vals[(i+2)%4]};
            pending_samples.push_back(d);
        end
        queue_random(300);
        wait_drained();

        set_period(16'd1);
        queue_random(300);
        wait_drained();
        set_period(16'($urandom_range(1, 65535)));
        queue_random(400);
        wait_drained();
        set_period(givr_pkg::PERIOD_RESET);
        queue_random(400);
        wait_drained();
        set_period(16'($urandom_range(100, 20000)));
        calm = 1'b1;
        queue_random(520);
        wait_drained();

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
